@@ rtl/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg: shared types, constants and microcode for the ping-pong delay
// Frame payload structs, register indexes, and the sequencer program ROM.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Delay line depth per channel; keep it a power of two so pointers wrap.
  localparam int STORE_DEPTH = 131072;
  localparam int PTR_W       = $clog2(STORE_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int DLY_W    = 17;
  localparam int FB_W     = 15;
  localparam int GAIN_W   = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE     = 16'd32768;
  localparam logic [FB_W-1:0]   FEEDBACK_MAX = 15'd29491;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROSSFEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } frame_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } frame_out_t;

  // Multiplier operand selection.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DR_CF,
    MUL_DL_CF,
    MUL_T0_FB,
    MUL_T1_FB,
    MUL_DIFF_WID,
    MUL_L_DRY,
    MUL_WL_MIX,
    MUL_R_DRY,
    MUL_WR_MIX
  } mul_op_t;

  // Write-back of the previous step's product.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_LOAD,
    WB_T0,
    WB_T1,
    WB_FB_L,
    WB_FB_R,
    WB_SIDE,
    WB_ACC,
    WB_OL,
    WB_DONE
  } wb_op_t;

  // Step counter control.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_FINISH
  } seq_op_t;

  typedef struct packed {
    mul_op_t mul;
    wb_op_t  wb;
    seq_op_t seq;
  } ctrl_word_t;

  localparam int PROG_LEN = 12;
  localparam int PC_W     = $clog2(PROG_LEN);

  function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      4'd0:    cw = '{MUL_NONE,     WB_NONE, SEQ_WAIT_IN};
      4'd1:    cw = '{MUL_NONE,     WB_LOAD, SEQ_NEXT};
      4'd2:    cw = '{MUL_DR_CF,    WB_NONE, SEQ_NEXT};
      4'd3:    cw = '{MUL_DL_CF,    WB_T0,   SEQ_NEXT};
      4'd4:    cw = '{MUL_T0_FB,    WB_T1,   SEQ_NEXT};
      4'd5:    cw = '{MUL_T1_FB,    WB_FB_L, SEQ_NEXT};
      4'd6:    cw = '{MUL_DIFF_WID, WB_FB_R, SEQ_NEXT};
      4'd7:    cw = '{MUL_L_DRY,    WB_SIDE, SEQ_NEXT};
      4'd8:    cw = '{MUL_WL_MIX,   WB_ACC,  SEQ_NEXT};
      4'd9:    cw = '{MUL_R_DRY,    WB_OL,   SEQ_NEXT};
      4'd10:   cw = '{MUL_WR_MIX,   WB_ACC,  SEQ_NEXT};
      4'd11:   cw = '{MUL_NONE,     WB_DONE, SEQ_FINISH};
      default: cw = '{MUL_NONE,     WB_NONE, SEQ_FINISH};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/stereo_ping_pong_delay.sv @@
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay: stereo echo with crossed feedback
// Microcoded sequencer over one shared multiplier and two delay-line RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one stereo frame per beat; out_valid/
//   out_stall/out_data return one processed frame per input beat, in order.
//   cfg_we/cfg_index/cfg_data write the five control registers; write them
//   only while no frame is in flight.
// Timing:
//   A beat is taken only when the sequencer sits at its entry step. The
//   program runs twelve steps, one per cycle unless the last step holds, through
//   a single 18x17 multiplier; the next frame is taken only after the program
//   returns to its entry step. The step count is set by the nine products
//   that share the multiplier plus the entry, load and finish steps.
// Stall:
//   The result sits in an output register; a new frame is accepted while it
//   waits. If the next result is done before the old one is taken, the last
//   step holds until out_stall drops.
// Reset:
//   Registers return to their defaults and the write pointer to zero. The
//   delay RAMs are not swept: a wrap flag and the write pointer tell which
//   entries were written since reset, and unwritten entries read as zero.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spp_pkg::frame_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output spp_pkg::frame_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [spp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spp_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PTR_W  = spp_pkg::PTR_W;
  localparam int SW     = spp_pkg::SAMPLE_W;
  localparam int A_W    = 18;                    // multiplier signed operand
  localparam int B_W    = spp_pkg::GAIN_W;       // multiplier unsigned operand
  localparam int PROD_W = A_W + B_W + 1;
  localparam int ACC_W  = 36;
  localparam int T_W    = 17;

  // Control registers
  logic [spp_pkg::DLY_W-1:0]  dly_r;
  logic [spp_pkg::FB_W-1:0]   fb_r;
  logic [spp_pkg::GAIN_W-1:0] cf_r;
  logic [spp_pkg::GAIN_W-1:0] mix_r;
  logic [spp_pkg::GAIN_W-1:0] wid_r;

  // Sequencer
  logic [spp_pkg::PC_W-1:0] pc_r, pc_nxt;
  spp_pkg::ctrl_word_t      cw;
  logic                     in_accept;
  logic                     out_hold;

  // Datapath
  logic signed [SW-1:0]     l_in_r, r_in_r;
  logic signed [SW-1:0]     dl_r, dr_r;
  logic signed [T_W-1:0]    t0_r, t1_r, s_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SW-1:0]     ol_r;
  logic signed [A_W-1:0]    mul_a;
  logic [B_W-1:0]           mul_b;
  logic signed [ACC_W-1:0]  p_ext;
  logic signed [ACC_W-1:0]  p_rnd15;
  logic signed [ACC_W-1:0]  mix_rnd16;
  logic signed [A_W-1:0]    dl_x, dr_x, s_x;

  // Delay lines
  logic signed [SW-1:0]     left_mem  [spp_pkg::STORE_DEPTH];
  logic signed [SW-1:0]     right_mem [spp_pkg::STORE_DEPTH];
  logic signed [SW-1:0]     rd_l_r, rd_r_r;
  logic [PTR_W-1:0]         wp_r;
  logic                     wrapped_r;
  logic [PTR_W-1:0]         rp;
  logic [PTR_W-1:0]         dly_mod;
  logic [spp_pkg::DLY_W+PTR_W-1:0] dly_ext;
  logic                     rd_ok;
  logic                     we_l, we_r;
  logic signed [SW-1:0]     fb_l_val, fb_r_val;

  // Effective gains after clamping
  logic [spp_pkg::FB_W-1:0]   fb_eff;
  logic [spp_pkg::GAIN_W-1:0] cf_eff, mix_eff, wid_eff, dry;

  function automatic logic signed [ACC_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
    return (v + ACC_W'(16384)) >>> 15;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
    return (v + ACC_W'(32768)) >>> 16;
  endfunction

  function automatic logic signed [SW-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [SW-1:0] r;
    if (v > ACC_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < ACC_W'(-32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: store raw, clamp at use
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r <= 17'd22050;
      fb_r  <= 15'd9830;
      cf_r  <= 16'd16384;
      mix_r <= 16'd16384;
      wid_r <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spp_pkg::REG_DELAY:     dly_r <= cfg_data[spp_pkg::DLY_W-1:0];
        spp_pkg::REG_FEEDBACK:  fb_r  <= cfg_data[spp_pkg::FB_W-1:0];
        spp_pkg::REG_CROSSFEED: cf_r  <= cfg_data[spp_pkg::GAIN_W-1:0];
        spp_pkg::REG_WET_MIX:   mix_r <= cfg_data[spp_pkg::GAIN_W-1:0];
        spp_pkg::REG_WIDTH:     wid_r <= cfg_data[spp_pkg::GAIN_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign fb_eff  = (fb_r  > spp_pkg::FEEDBACK_MAX) ? spp_pkg::FEEDBACK_MAX : fb_r;
  assign cf_eff  = (cf_r  > spp_pkg::GAIN_ONE) ? spp_pkg::GAIN_ONE : cf_r;
  assign mix_eff = (mix_r > spp_pkg::GAIN_ONE) ? spp_pkg::GAIN_ONE : mix_r;
  assign wid_eff = (wid_r > spp_pkg::GAIN_ONE) ? spp_pkg::GAIN_ONE : wid_r;
  assign dry     = spp_pkg::GAIN_ONE - mix_eff;

  // --------------------------------------------------------------------------
  // Sequencer: fetch the control word for the current step
  // --------------------------------------------------------------------------
  assign cw        = spp_pkg::prog_rom(pc_r);
  assign in_stall  = (pc_r != '0);
  assign in_accept = in_valid && !in_stall;
  // Hold the last step while the previous result has not been taken.
  assign out_hold  = out_valid && out_stall;

  always_comb begin
    unique case (cw.seq)
      spp_pkg::SEQ_NEXT:    pc_nxt = pc_r + 1'b1;
      spp_pkg::SEQ_WAIT_IN: pc_nxt = in_accept ? pc_r + 1'b1 : pc_r;
      spp_pkg::SEQ_FINISH:  pc_nxt = out_hold ? pc_r : '0;
      default:              pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Delay line addressing: delay taken modulo the depth
  // --------------------------------------------------------------------------
  assign dly_ext = {{PTR_W{1'b0}}, dly_r};
  assign dly_mod = dly_ext[PTR_W-1:0];
  assign rp      = wp_r - dly_mod;
  // An entry is live once written since reset; delay zero bypasses the RAM.
  assign rd_ok   = wrapped_r || (rp < wp_r);

  assign we_l = (cw.wb == spp_pkg::WB_FB_L);
  assign we_r = (cw.wb == spp_pkg::WB_FB_R);

  always_ff @(posedge clk) begin
    if (we_l) begin
      left_mem[wp_r] <= fb_l_val;
    end
    rd_l_r <= left_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (we_r) begin
      right_mem[wp_r] <= fb_r_val;
    end
    rd_r_r <= right_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (cw.wb == spp_pkg::WB_DONE && !out_hold) begin
      // Advance once per frame; note the first wrap.
      wp_r <= wp_r + 1'b1;
      if (wp_r == PTR_W'(spp_pkg::STORE_DEPTH - 1)) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier, registered product
  // --------------------------------------------------------------------------
  assign dl_x = {{(A_W-SW){dl_r[SW-1]}}, dl_r};
  assign dr_x = {{(A_W-SW){dr_r[SW-1]}}, dr_r};
  assign s_x  = {{(A_W-T_W){s_r[T_W-1]}}, s_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.mul)
      spp_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      spp_pkg::MUL_DR_CF: begin
        mul_a = dr_x;
        mul_b = cf_eff;
      end
      spp_pkg::MUL_DL_CF: begin
        mul_a = dl_x;
        mul_b = cf_eff;
      end
      spp_pkg::MUL_T0_FB: begin
        mul_a = {{(A_W-T_W){t0_r[T_W-1]}}, t0_r};
        mul_b = {1'b0, fb_eff};
      end
      spp_pkg::MUL_T1_FB: begin
        mul_a = {{(A_W-T_W){t1_r[T_W-1]}}, t1_r};
        mul_b = {1'b0, fb_eff};
      end
      spp_pkg::MUL_DIFF_WID: begin
        mul_a = dl_x - dr_x;
        mul_b = wid_eff;
      end
      spp_pkg::MUL_L_DRY: begin
        mul_a = {{(A_W-SW){l_in_r[SW-1]}}, l_in_r};
        mul_b = dry;
      end
      spp_pkg::MUL_WL_MIX: begin
        mul_a = dl_x + dr_x + s_x;
        mul_b = mix_eff;
      end
      spp_pkg::MUL_R_DRY: begin
        mul_a = {{(A_W-SW){r_in_r[SW-1]}}, r_in_r};
        mul_b = dry;
      end
      spp_pkg::MUL_WR_MIX: begin
        mul_a = dl_x + dr_x - s_x;
        mul_b = mix_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.mul != spp_pkg::MUL_NONE) begin
      p_r <= PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
    end
  end

  assign p_ext     = {{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r};
  assign p_rnd15   = rnd15(p_ext);
  assign mix_rnd16 = rnd16(acc_r + p_ext);

  // Feedback into the store: input plus the other channel's delayed echo.
  assign fb_l_val = sat16({{(ACC_W-SW){l_in_r[SW-1]}}, l_in_r} + p_rnd15);
  assign fb_r_val = sat16({{(ACC_W-SW){r_in_r[SW-1]}}, r_in_r} + p_rnd15);

  // --------------------------------------------------------------------------
  // Write-back of the previous product
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      l_in_r <= in_data.left_in;
      r_in_r <= in_data.right_in;
    end
    case (cw.wb)
      spp_pkg::WB_LOAD: begin
        if (dly_mod == '0) begin
          dl_r <= l_in_r;
          dr_r <= r_in_r;
        end else if (rd_ok) begin
          dl_r <= rd_l_r;
          dr_r <= rd_r_r;
        end else begin
          dl_r <= '0;
          dr_r <= '0;
        end
      end
      spp_pkg::WB_T0:   t0_r  <= p_rnd15[T_W-1:0];
      spp_pkg::WB_T1:   t1_r  <= p_rnd15[T_W-1:0];
      spp_pkg::WB_SIDE: s_r   <= p_rnd15[T_W-1:0];
      spp_pkg::WB_ACC:  acc_r <= p_ext <<< 1;
      spp_pkg::WB_OL:   ol_r  <= sat16(mix_rnd16);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cw.wb == spp_pkg::WB_DONE && !out_hold) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.wb == spp_pkg::WB_DONE && !out_hold) begin
      out_data.left_out  <= ol_r;
      out_data.right_out <= sat16(mix_rnd16);
    end
  end

endmodule

@@ rtl/spp_checker.sv @@
// ----------------------------------------------------------------------------
// spp_checker: port-level checks for the ping-pong delay
// Watches the handshakes and reset behavior seen at the top level.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spp_pkg::frame_out_t out_data
);

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  // The program stays busy through its last step after taking a beat.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> ##11 in_stall)
    else $error("input taken before the frame program finished");

  // No result can start in the cycle after a beat is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !$rose(out_valid))
    else $error("result appeared right after an input beat");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // After reset the block is empty and ready.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind stereo_ping_pong_delay spp_checker u_spp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/stereo_ping_pong_delay_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay_tb: self-checking bench for the stereo echo block
// A directed table of frames and register writes runs first: reset
// defaults, sample extremes, gains above one, clamped feedback, saturating
// store writes, the longest delay and ignored register indexes. Random
// phases follow, each with its own register setting and frame content.
// Every accepted frame is run through a bit-exact echo predictor, and each
// result beat is checked against the oldest prediction. Both sides idle
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay_tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_FRAMES = 1050;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 24;
  localparam int REPORT_LIMIT  = 10;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [spp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [spp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // One row of the directed table: a register write or a frame, the frame
  // optionally with a result that is obvious from the arithmetic.
  typedef struct {
    bit                            is_cfg;
    logic [spp_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [spp_pkg::CFG_W-1:0]     reg_val;
    spp_pkg::frame_in_t            frame;
    bit                            has_gold;
    spp_pkg::frame_out_t           gold;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  spp_pkg::frame_in_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  spp_pkg::frame_out_t           out_data;
  logic                          cfg_we;
  logic [spp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [spp_pkg::CFG_W-1:0]     cfg_data;

  // Echo predictor state: both delay lines, the write head and the
  // register copies it computes from.
  logic signed [spp_pkg::SAMPLE_W-1:0] echo_left  [spp_pkg::STORE_DEPTH];
  logic signed [spp_pkg::SAMPLE_W-1:0] echo_right [spp_pkg::STORE_DEPTH];
  logic [spp_pkg::PTR_W-1:0]           write_head;
  logic [spp_pkg::DLY_W-1:0]           model_delay;
  logic [spp_pkg::FB_W-1:0]            model_feedback;
  logic [spp_pkg::GAIN_W-1:0]          model_crossfeed;
  logic [spp_pkg::GAIN_W-1:0]          model_wet;
  logic [spp_pkg::GAIN_W-1:0]          model_width;

  spp_pkg::frame_out_t  due_frames[$];
  spp_pkg::frame_out_t  due_now;
  plan_row_t            plan[$];

  int unsigned send_gap_pct   = 21;
  int unsigned recv_stall_pct = 59;
  bit          hold_wanted    = 1'b0;
  bit          hold_served    = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned cycle_count    = 0;
  int unsigned frames_sent    = 0;
  int unsigned frames_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatches     = 0;

  stereo_ping_pong_delay u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Echo arithmetic
  // ---------------------------------------------------------------------------

  // Shift right with round half up; >>> on a signed longint floors.
  function automatic longint round_q(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [spp_pkg::SAMPLE_W-1:0] sat_sample(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[spp_pkg::SAMPLE_W-1:0];
  endfunction

  // Process one frame: store it, read the delayed pair, fold the crossed
  // feedback into the entry just written, then widen and mix.
  function automatic spp_pkg::frame_out_t predict_echo(input spp_pkg::frame_in_t f);
    logic [spp_pkg::PTR_W-1:0] wp;
    logic [spp_pkg::PTR_W-1:0] rp;
    longint l, r, dl, dr, fb, cf, mix, wid, t, s;
    spp_pkg::frame_out_t res;
    l   = f.left_in;
    r   = f.right_in;
    wp  = write_head;
    rp  = wp - model_delay[spp_pkg::PTR_W-1:0];
    // Clamp gains above one and feedback above its ceiling.
    fb  = (model_feedback > spp_pkg::FEEDBACK_MAX) ? spp_pkg::FEEDBACK_MAX : model_feedback;
    cf  = (model_crossfeed > spp_pkg::GAIN_ONE) ? spp_pkg::GAIN_ONE : model_crossfeed;
    mix = (model_wet > spp_pkg::GAIN_ONE) ? spp_pkg::GAIN_ONE : model_wet;
    wid = (model_width > spp_pkg::GAIN_ONE) ? spp_pkg::GAIN_ONE : model_width;

    echo_left[wp]  = l[spp_pkg::SAMPLE_W-1:0];
    echo_right[wp] = r[spp_pkg::SAMPLE_W-1:0];
    // Read after the write so that a zero delay returns this frame.
    dl = echo_left[rp];
    dr = echo_right[rp];

    // Feedback crosses over: left line takes the right echo and back.
    t = round_q(dr * cf, 15);
    echo_left[wp]  = sat_sample(l + round_q(t * fb, 15));
    t = round_q(dl * cf, 15);
    echo_right[wp] = sat_sample(r + round_q(t * fb, 15));

    s = round_q((dl - dr) * wid, 15);
    res.left_out  = sat_sample(round_q(2 * l * (longint'(spp_pkg::GAIN_ONE) - mix)
                                       + (dl + dr + s) * mix, 16));
    res.right_out = sat_sample(round_q(2 * r * (longint'(spp_pkg::GAIN_ONE) - mix)
                                       + (dl + dr - s) * mix, 16));
    write_head = wp + 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cfg_row(input logic [spp_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [spp_pkg::CFG_W-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t frame_row(input int l, input int r);
    plan_row_t row;
    row = '{default: '0};
    row.frame.left_in  = 16'(l);
    row.frame.right_in = 16'(r);
    return row;
  endfunction

  function automatic plan_row_t gold_row(input int l, input int r,
                                         input int gl, input int gr);
    plan_row_t row;
    row = frame_row(l, r);
    row.has_gold       = 1'b1;
    row.gold.left_out  = 16'(gl);
    row.gold.right_out = 16'(gr);
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  function automatic logic [spp_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom);
      4:       return 16'($urandom_range(0, 128) - 64);
      5:       return '0;
      default: return 16'($urandom_range(0, 16000) - 8000);
    endcase
  endfunction

  // Gain register data; the top data bit lies above the field and is dropped.
  function automatic logic [spp_pkg::CFG_W-1:0] pick_gain();
    logic [spp_pkg::GAIN_W-1:0] g;
    case ($urandom_range(0, 7))
      0:       g = '0;
      1:       g = spp_pkg::GAIN_ONE;
      2:       g = '1;
      3:       g = 16'($urandom);
      default: g = 16'($urandom_range(0, 32768));
    endcase
    return {1'($urandom_range(0, 1)), g};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge, handshakes resolve on the rising
  // ---------------------------------------------------------------------------

  // Offer one beat, leave valid high once taken, and queue its prediction.
  task automatic send_frame(input spp_pkg::frame_in_t f, input bit has_gold,
                            input spp_pkg::frame_out_t gold);
    spp_pkg::frame_out_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = f;
    do @(posedge clk); while (in_stall);
    predicted = predict_echo(f);
    due_frames.push_back(has_gold ? gold : predicted);
    frames_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [spp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      spp_pkg::REG_DELAY:     model_delay     = val[spp_pkg::DLY_W-1:0];
      spp_pkg::REG_FEEDBACK:  model_feedback  = val[spp_pkg::FB_W-1:0];
      spp_pkg::REG_CROSSFEED: model_crossfeed = val[spp_pkg::GAIN_W-1:0];
      spp_pkg::REG_WET_MIX:   model_wet       = val[spp_pkg::GAIN_W-1:0];
      spp_pkg::REG_WIDTH:     model_width     = val[spp_pkg::GAIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_served) begin
        hold_left   = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each taken beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      frames_checked++;
      if (due_frames.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("Result beat with nothing pending: L=%0d R=%0d",
                   out_data.left_out, out_data.right_out);
        mismatches++;
      end else begin
        due_now = due_frames.pop_front();
        if (out_data.left_out !== due_now.left_out ||
            out_data.right_out !== due_now.right_out) begin
          if (mismatches < REPORT_LIMIT)
            $display("Result %0d wrong: expected L=%0d R=%0d, got L=%0d R=%0d",
                     frames_checked, due_now.left_out, due_now.right_out,
                     out_data.left_out, out_data.right_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, due_frames.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned         random_sent;
    int unsigned         phase_len;
    int unsigned         phases;
    int unsigned         directed_frames;
    int unsigned         delay_pick;
    int unsigned         fb_pick;
    bit                  impulse_phase;
    spp_pkg::frame_in_t  f;
    spp_pkg::frame_out_t no_gold;

    random_sent     = 0;
    phases          = 0;
    directed_frames = 0;
    no_gold         = '0;

    // Hold every input at a known value through reset.
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = spp_pkg::REG_DELAY;
    cfg_data  = '0;

    // Predictor starts where reset leaves the block: empty lines, defaults.
    foreach (echo_left[i]) begin
      echo_left[i]  = '0;
      echo_right[i] = '0;
    end
    write_head      = '0;
    model_delay     = 17'd22050;
    model_feedback  = 15'd9830;
    model_crossfeed = 16'd16384;
    model_wet       = 16'd16384;
    model_width     = 16'd16384;

    // Reset defaults: the long delay reads silence, so the output is half
    // the dry input, rounded half up.
    plan.push_back(gold_row(0, 0, 0, 0));
    plan.push_back(gold_row(32767, -32768, 16384, -16384));
    plan.push_back(gold_row(-1, 1, 0, 1));
    // Writes past the register list are dropped.
    plan.push_back(cfg_row(REG_SPARE_LO, 17'h1FFFF));
    plan.push_back(cfg_row(REG_SPARE_HI, 17'h1FFFF));
    plan.push_back(gold_row(-1, 1, 0, 1));
    // All dry: the input comes straight through.
    plan.push_back(cfg_row(spp_pkg::REG_WET_MIX, 17'd0));
    plan.push_back(cfg_row(spp_pkg::REG_DELAY, 17'd0));
    plan.push_back(gold_row(32767, -32768, 32767, -32768));
    plan.push_back(gold_row(-32768, 32767, -32768, 32767));
    // Gains above one act as one: zero delay, full wet and full width
    // give back the input.
    plan.push_back(cfg_row(spp_pkg::REG_WET_MIX, 17'h0FFFF));
    plan.push_back(cfg_row(spp_pkg::REG_WIDTH, 17'h0FFFF));
    plan.push_back(gold_row(12345, -2222, 12345, -2222));
    plan.push_back(gold_row(-32768, 32767, -32768, 32767));
    // No width: both outputs carry the mid signal.
    plan.push_back(cfg_row(spp_pkg::REG_WIDTH, 17'd0));
    plan.push_back(gold_row(32767, 32767, 32767, 32767));
    plan.push_back(gold_row(-32768, -32768, -32768, -32768));
    // One-frame delay, feedback written past its ceiling and full crossfeed:
    // full-scale frames drive the line entries into saturation.
    plan.push_back(cfg_row(spp_pkg::REG_DELAY, 17'd1));
    plan.push_back(cfg_row(spp_pkg::REG_FEEDBACK, 17'h1FFFF));
    plan.push_back(cfg_row(spp_pkg::REG_CROSSFEED, 17'h0FFFF));
    plan.push_back(cfg_row(spp_pkg::REG_WIDTH, 17'd32769));
    plan.push_back(cfg_row(spp_pkg::REG_WET_MIX, 17'd32768));
    plan.push_back(frame_row(32767, -32768));
    plan.push_back(frame_row(-32768, 32767));
    plan.push_back(frame_row(32767, 32767));
    plan.push_back(frame_row(30000, -30000));
    plan.push_back(frame_row(0, 0));
    plan.push_back(frame_row(0, 0));
    // Longest delay reads entries not yet written; all wet gives silence.
    plan.push_back(cfg_row(spp_pkg::REG_DELAY, 17'h1FFFF));
    plan.push_back(gold_row(1000, -1000, 0, 0));
    plan.push_back(gold_row(32767, -32768, 0, 0));
    // An impulse bouncing between channels at the feedback ceiling.
    plan.push_back(cfg_row(spp_pkg::REG_DELAY, 17'd2));
    plan.push_back(cfg_row(spp_pkg::REG_FEEDBACK, 17'd29491));
    plan.push_back(cfg_row(spp_pkg::REG_CROSSFEED, 17'd32768));
    plan.push_back(cfg_row(spp_pkg::REG_WET_MIX, 17'd16384));
    plan.push_back(cfg_row(spp_pkg::REG_WIDTH, 17'd16384));
    plan.push_back(frame_row(20000, 0));
    repeat (4) plan.push_back(frame_row(0, 0));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Walk the table; drain before each register write so the block is idle.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle_block();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_frame(plan[i].frame, plan[i].has_gold, plan[i].gold);
        directed_frames++;
      end
    end

    // Random phases: a fresh setting each, mostly short delays so echoes
    // build up and feed back within the run.
    while (random_sent < RANDOM_FRAMES) begin
      settle_block();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: delay_pick = $urandom_range(0, 6);
        5, 6:          delay_pick = $urandom_range(7, 400);
        7:             delay_pick = $urandom_range(0, 131071);
        8:             delay_pick = 131071;
        default:       delay_pick = 0;
      endcase
      case ($urandom_range(0, 4))
        0:       fb_pick = 0;
        1:       fb_pick = spp_pkg::FEEDBACK_MAX;
        2:       fb_pick = $urandom_range(29492, 131071);
        default: fb_pick = $urandom_range(0, 29491);
      endcase
      write_reg(spp_pkg::REG_DELAY, 17'(delay_pick));
      write_reg(spp_pkg::REG_FEEDBACK, 17'(fb_pick));
      write_reg(spp_pkg::REG_CROSSFEED, pick_gain());
      write_reg(spp_pkg::REG_WET_MIX, pick_gain());
      write_reg(spp_pkg::REG_WIDTH, pick_gain());
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 17'($urandom));
      phases++;

      // Sender-light then receiver-light idling, then none at all.
      if (random_sent < RANDOM_FRAMES / 3) begin
        send_gap_pct   = 21;
        recv_stall_pct = 59;
      end else if (random_sent < 2 * RANDOM_FRAMES / 3) begin
        send_gap_pct   = 59;
        recv_stall_pct = 21;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        // Back up the result side while frames keep coming in.
        hold_wanted    = 1'b1;
      end

      phase_len     = $urandom_range(40, 160);
      impulse_phase = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && random_sent < RANDOM_FRAMES; k++) begin
        // Impulse phases: a burst now and then, silence to let it ring.
        if (impulse_phase && (k % 24) != 0) begin
          f = '0;
        end else begin
          f.left_in  = pick_sample();
          f.right_in = pick_sample();
        end
        send_frame(f, 1'b0, no_gold);
        random_sent++;
      end
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames (%0d from the directed table), %0d register writes,",
             frames_sent, directed_frames, reg_writes);
    $display("%0d random settings, %0d result beats compared, one %0d-cycle hold-off.",
             phases, frames_checked, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/spp_pkg.sv
rtl/stereo_ping_pong_delay.sv
rtl/spp_checker.sv
tb/stereo_ping_pong_delay_tb.sv
